### sv/rgb_to_hsv_converter_core_macros.svh
// Assertion helpers for the RGB to HSV core
`ifndef RGB_TO_HSV_CONVERTER_CORE_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define RHSV_ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define RHSV_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error(msg);

`endif

### sv/rhsv_pkg.sv
package rhsv_pkg;

	// channel and result widths
	localparam int CH_W  = 8;
	localparam int HUE_W = 13;

	// quotient bits per divider, one per cell
	localparam int QBITS = 10;
	// dividend width: 960 * 255 needs 18 bits
	localparam int NUM_W = CH_W + QBITS;

	localparam int HUE_SIXTH  = 960;
	localparam int HUE_CIRCLE = 5760;
	localparam int SAT_SCALE  = 255;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	// one restoring-division lane
	typedef struct packed {
		logic [CH_W-1:0]  rem;
		logic [QBITS-1:0] num;
		logic [QBITS-1:0] quo;
		logic [CH_W-1:0]  dvs;
	} div_lane_t;

	// per-pixel data riding alongside the dividers
	typedef struct packed {
		sector_t         sector;
		logic            neg;
		logic            grey;
		logic            black;
		logic [CH_W-1:0] bright;
	} pix_side_t;

endpackage

### sv/rhsv_front.sv
module rhsv_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   valid_in,
	input  logic [rhsv_pkg::CH_W-1:0] red,
	input  logic [rhsv_pkg::CH_W-1:0] green,
	input  logic [rhsv_pkg::CH_W-1:0] blue,
	output logic                   valid_s1,
	output rhsv_pkg::pix_side_t    side_s1,
	output rhsv_pkg::div_lane_t    hue_lane_s1,
	output rhsv_pkg::div_lane_t    sat_lane_s1
);
	import rhsv_pkg::*;

	logic [CH_W-1:0]  mx, mn, delta, abs_diff;
	logic signed [CH_W:0] diff;
	sector_t          sector;
	logic [NUM_W-1:0] hue_num, sat_num;
	pix_side_t        side_d;
	div_lane_t        hue_d, sat_d;

	// max, min and sector; ties go to the earlier channel
	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		delta = mx - mn;
		if (mx == red) begin
			sector = SEC_RED;
			diff   = $signed({1'b0, green}) - $signed({1'b0, blue});
		end else if (mx == green) begin
			sector = SEC_GREEN;
			diff   = $signed({1'b0, blue}) - $signed({1'b0, red});
		end else begin
			sector = SEC_BLUE;
			diff   = $signed({1'b0, red}) - $signed({1'b0, green});
		end
		abs_diff = diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];
	end

	// scaled dividends; quotient fits QBITS since |diff| <= delta <= max
	always_comb begin
		hue_num = NUM_W'(abs_diff) * NUM_W'(HUE_SIXTH);
		sat_num = NUM_W'(delta) * NUM_W'(SAT_SCALE);

		hue_d.rem = hue_num[NUM_W-1:QBITS];
		hue_d.num = hue_num[QBITS-1:0];
		hue_d.quo = '0;
		hue_d.dvs = delta;

		sat_d.rem = sat_num[NUM_W-1:QBITS];
		sat_d.num = sat_num[QBITS-1:0];
		sat_d.quo = '0;
		sat_d.dvs = mx;

		side_d.sector = sector;
		side_d.neg    = diff[CH_W];
		side_d.grey   = (delta == '0);
		side_d.black  = (mx == '0);
		side_d.bright = mx;
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1     <= side_d;
			hue_lane_s1 <= hue_d;
			sat_lane_s1 <= sat_d;
		end
	end

endmodule

### sv/rhsv_cell.sv
module rhsv_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_in,
	input  rhsv_pkg::pix_side_t side_in,
	input  rhsv_pkg::div_lane_t hue_in,
	input  rhsv_pkg::div_lane_t sat_in,
	output logic                valid_q,
	output rhsv_pkg::pix_side_t side_q,
	output rhsv_pkg::div_lane_t hue_q,
	output rhsv_pkg::div_lane_t sat_q
);
	import rhsv_pkg::*;

	// one restoring step: bring down a dividend bit, subtract if it fits
	function automatic div_lane_t div_step(input div_lane_t l);
		logic [CH_W:0] trial;
		logic          fits;
		div_lane_t     o;
		trial = {l.rem, l.num[QBITS-1]};
		fits  = (trial >= {1'b0, l.dvs});
		o     = l;
		o.rem = fits ? CH_W'(trial - {1'b0, l.dvs}) : trial[CH_W-1:0];
		o.num = {l.num[QBITS-2:0], 1'b0};
		o.quo = {l.quo[QBITS-2:0], fits};
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_in;
			hue_q  <= div_step(hue_in);
			sat_q  <= div_step(sat_in);
		end
	end

endmodule

### sv/rhsv_back.sv
module rhsv_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid_in,
	input  rhsv_pkg::pix_side_t           side_in,
	input  rhsv_pkg::div_lane_t           hue_in,
	input  rhsv_pkg::div_lane_t           sat_in,
	output logic                          valid_q,
	output logic [rhsv_pkg::HUE_W-1:0]    hue_q,
	output logic [rhsv_pkg::CH_W-1:0]     sat_q,
	output logic [rhsv_pkg::CH_W-1:0]     bright_q
);
	import rhsv_pkg::*;

	logic [HUE_W-1:0]    base, hue_d;
	logic [QBITS:0]      ceil_q;
	logic signed [HUE_W:0] neg_hue;

	// sector offset
	always_comb begin
		unique case (side_in.sector)
			SEC_RED:   base = '0;
			SEC_GREEN: base = HUE_W'(2 * HUE_SIXTH);
			SEC_BLUE:  base = HUE_W'(4 * HUE_SIXTH);
			default:   base = '0;
		endcase
	end

	// floor rounding: a negative difference takes the ceiling of the magnitude
	always_comb begin
		ceil_q  = {1'b0, hue_in.quo} + (QBITS+1)'(hue_in.rem != '0);
		neg_hue = $signed({1'b0, base}) - $signed((HUE_W+1)'(ceil_q));
		if (neg_hue < 0) neg_hue = neg_hue + (HUE_W+1)'(HUE_CIRCLE);
		if (side_in.grey) begin
			hue_d = '0;
		end else if (side_in.neg) begin
			hue_d = neg_hue[HUE_W-1:0];
		end else begin
			hue_d = base + HUE_W'(hue_in.quo);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			hue_q    <= hue_d;
			sat_q    <= side_in.black ? '0 : sat_in.quo[CH_W-1:0];
			bright_q <= side_in.bright;
		end
	end

endmodule

### sv/rgb_to_hsv_converter_core.sv
// Pipeline: 1 front stage, 10 divider cells and 1 output stage between input transfer and result.
// Throughput: one pixel per clock while the output is not held; the rate is set by the row of divider cells,
// each resolving one quotient bit of hue and saturation per cycle.
// When the output is held, every stage holds and s_tready drops.
// Reset: arst_n clears all stage valid bits; the payload registers are not reset.
module rgb_to_hsv_converter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // red[7:0], green[15:8], blue[23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // hue[12:0], saturation[20:13], brightness[28:21], zero
);
	import rhsv_pkg::*;

	`include "rgb_to_hsv_converter_core_macros.svh"

	logic      en;
	logic      valid_c [QBITS+1];
	pix_side_t side_c  [QBITS+1];
	div_lane_t hue_c   [QBITS+1];
	div_lane_t sat_c   [QBITS+1];

	logic [HUE_W-1:0] hue;
	logic [CH_W-1:0]  saturation, brightness;

	// whole pipe advances unless a result is waiting and not taken
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	rhsv_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.valid_in    (s_tvalid),
		.red         (s_tdata[7:0]),
		.green       (s_tdata[15:8]),
		.blue        (s_tdata[23:16]),
		.valid_s1    (valid_c[0]),
		.side_s1     (side_c[0]),
		.hue_lane_s1 (hue_c[0]),
		.sat_lane_s1 (sat_c[0])
	);

	// divider row, one quotient bit per cell
	for (genvar i = 0; i < QBITS; i++) begin : g_cell
		rhsv_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (valid_c[i]),
			.side_in  (side_c[i]),
			.hue_in   (hue_c[i]),
			.sat_in   (sat_c[i]),
			.valid_q  (valid_c[i+1]),
			.side_q   (side_c[i+1]),
			.hue_q    (hue_c[i+1]),
			.sat_q    (sat_c[i+1])
		);
	end

	rhsv_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (valid_c[QBITS]),
		.side_in  (side_c[QBITS]),
		.hue_in   (hue_c[QBITS]),
		.sat_in   (sat_c[QBITS]),
		.valid_q  (m_tvalid),
		.hue_q    (hue),
		.sat_q    (saturation),
		.bright_q (brightness)
	);

	assign m_tdata = {3'b000, brightness, saturation, hue};

	// checks
	`RHSV_ASSERT_IMPL(a_hue_range, clk, arst_n, m_tvalid, hue < HUE_W'(HUE_CIRCLE), "hue out of range")
	`RHSV_ASSERT_IMPL(a_grey_hue, clk, arst_n, m_tvalid && saturation == '0, hue == '0, "grey pixel with nonzero hue")
	`RHSV_ASSERT_IMPL(a_black_sat, clk, arst_n, m_tvalid && brightness == '0, saturation == '0, "black pixel with nonzero saturation")

endmodule
